// File: rtl/bfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants for the balanced bucket allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int NumBuckets = 256;
  localparam int CountWidth = 32;
  localparam int IdxW       = $clog2(NumBuckets);
  localparam int TotW       = IdxW + 1;
  localparam int IdW        = 8;
  localparam int UsedW      = IdW + CountWidth;     // id and count packed together
  localparam int CmpW       = (CountWidth > TotW + 2) ? CountWidth : TotW + 2;
  localparam logic [CountWidth-1:0] CountMax = '1;
  localparam int MinOpenHalf = 4;

  typedef enum logic {
    CMD_ALLOC  = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    OUT_EXISTING = 3'd0,
    OUT_OPENED   = 3'd1,
    OUT_DECR     = 3'd2,
    OUT_FREED    = 3'd3,
    OUT_IGNORED  = 3'd4
  } outcome_t;

  typedef struct packed {
    logic           cmd;
    logic [IdW-1:0] bucket_id;
    logic [31:0]    random_word;
  } in_beat_t;

  typedef struct packed {
    logic [IdW-1:0] chosen_bucket;
    logic [2:0]     outcome;
  } out_beat_t;

endpackage

// File: rtl/bfa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/balanced_folder_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// balanced_folder_allocator_top
// Sequenced allocator keeping in-use buckets sorted by file count.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request beat (cmd, bucket_id, random_word), accepted when
//           in_valid is high and in_stall low. in_stall is low only in the
//           idle state, so one request is in flight at a time.
//   out_* : one result beat (chosen_bucket, outcome) per request, held in
//           an output register until out_stall is low. A new request may be
//           taken while an older result still waits there.
// Walks: list walks take one entry per address state and registered read
//   state, through one single-port RAM per list. A decrement searches for
//   the id and then walks left toward the front. The next beat is accepted
//   only from the idle state, after the result is written, so one beat is
//   handled at a time.
// Reset: after rst_n the block runs a clearing pass writing spare entry
//   i := i for every entry, with in_stall high meanwhile.
// Stall: out_stall only holds the result register; the sequencer waits in
//   its final state while a finished result cannot yet be written.
// ----------------------------------------------------------------------------
module balanced_folder_allocator_top
  import bfa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DEC,
    S_MED_A, S_MED_R,
    S_SP_RD_A, S_SP_RD_R,
    S_SPSH_A, S_SPSH_R,
    S_USH_A, S_USH_R,
    S_BP_A, S_BP_R, S_BP_SCAN_A, S_BP_SCAN_R,
    S_RM_A, S_RM_R,
    S_RF_A, S_RF_R, S_RF_SP,
    S_RD_A, S_RD_R,
    S_FIN_A, S_FIN_B,
    S_DONE
  } state_t;

  state_t state_r;

  logic             u_we;
  logic [IdxW-1:0]  u_addr;
  logic [UsedW-1:0] u_wdata, u_rdata;
  logic             s_we;
  logic [IdxW-1:0]  s_addr;
  logic [IdW-1:0]   s_wdata, s_rdata;

  bfa_ram #(.Width(UsedW), .Depth(NumBuckets)) u_used (
    .clk(clk), .we(u_we), .addr(u_addr), .wdata(u_wdata), .rdata(u_rdata));
  bfa_ram #(.Width(IdW), .Depth(NumBuckets)) u_spare (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata));

  logic [TotW-1:0]       used_total_r, spare_total_r;
  logic [TotW-1:0]       k_r;          // walk index
  logic [TotW-1:0]       i_r;          // anchor index
  logic [UsedW-1:0]      hold_r;       // carried entry
  logic [IdW-1:0]        bid_r;
  logic [31:0]           rnd_r;
  cmd_t                  cmd_r;
  logic [CountWidth-1:0] cnt_r;
  logic [IdW-1:0]        res_id_r;
  outcome_t              res_oc_r;
  logic                  ov_r;
  out_beat_t             od_r;

  logic [TotW-1:0] half;
  logic [TotW-1:0] k_inc, k_dec;
  assign half  = used_total_r >> 1;
  assign k_inc = k_r + TotW'(1);
  assign k_dec = k_r - TotW'(1);

  // shared random pick: (rnd * n) >> 32
  logic [TotW-1:0]  pick_n;
  logic [31+TotW:0] pick_p;
  logic [TotW-1:0]  pick_q;
  assign pick_n = (state_r == S_SP_RD_A) ? spare_total_r : half;
  assign pick_p = (32+TotW)'(rnd_r) * (32+TotW)'(pick_n);
  assign pick_q = pick_p[31+TotW:32];

  // 3*used/2 threshold
  logic [TotW+1:0] thr;
  assign thr = ({2'b00, used_total_r} + {1'b0, used_total_r, 1'b0}) >> 1;

  logic [IdW-1:0]        ru_id;
  logic [CountWidth-1:0] ru_cnt;
  logic [CountWidth-1:0] cnt_inc;
  assign ru_id   = u_rdata[UsedW-1:CountWidth];
  assign ru_cnt  = u_rdata[CountWidth-1:0];
  assign cnt_inc = (ru_cnt != CountMax) ? ru_cnt + CountWidth'(1) : ru_cnt;

  logic open_ok;
  assign open_ok = (spare_total_r != '0) && (used_total_r < TotW'(NumBuckets));

  logic out_free;
  assign out_free = !ov_r || !out_stall;

  // RAM ports: read data is registered and lands in the state after the address state
  always_comb begin
    u_we    = 1'b0;
    u_addr  = k_r[IdxW-1:0];
    u_wdata = hold_r;
    s_we    = 1'b0;
    s_addr  = k_r[IdxW-1:0];
    s_wdata = k_r[IdW-1:0];
    unique case (state_r)
      S_INIT:      s_we = 1'b1;
      S_MED_A:     u_addr = half[IdxW-1:0];
      S_SP_RD_A:   s_addr = pick_q[IdxW-1:0];
      S_SPSH_A:    s_addr = k_inc[IdxW-1:0];
      S_SPSH_R: begin
        s_we    = 1'b1;
        s_wdata = s_rdata;
      end
      // write carried entry at k while reading the old one out
      S_USH_A:     u_we = (k_r <= used_total_r);
      S_BP_A:      u_addr = pick_q[IdxW-1:0];
      S_BP_SCAN_A: u_addr = k_inc[IdxW-1:0];
      S_RF_A:      u_addr = k_inc[IdxW-1:0];
      S_RF_R: begin
        u_we    = 1'b1;
        u_wdata = u_rdata;
      end
      S_RF_SP: begin
        s_we    = (spare_total_r < TotW'(NumBuckets));
        s_addr  = spare_total_r[IdxW-1:0];
        s_wdata = bid_r;
      end
      S_RD_A:      u_addr = k_dec[IdxW-1:0];
      // swap: displaced entry back to the anchor, moved entry to k
      S_FIN_A: begin
        u_we   = (k_r != i_r);
        u_addr = i_r[IdxW-1:0];
      end
      S_FIN_B: begin
        u_we    = 1'b1;
        u_wdata = {res_id_r, cnt_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_INIT;
      k_r           <= '0;
      used_total_r  <= '0;
      spare_total_r <= TotW'(NumBuckets);
      ov_r          <= 1'b0;
    end else begin
      if (state_r == S_DONE && out_free) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT: begin
          k_r <= k_inc;
          if (k_r == TotW'(NumBuckets - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          cmd_r   <= cmd_t'(in_data.cmd);
          bid_r   <= in_data.bucket_id;
          rnd_r   <= in_data.random_word;
          state_r <= S_DEC;
        end
        S_DEC: begin
          if (cmd_r == CMD_REMOVE) begin
            k_r     <= '0;
            state_r <= S_RM_A;
          end else if (half < TotW'(MinOpenHalf)) begin
            state_r <= open_ok ? S_SP_RD_A : S_BP_A;
          end else begin
            state_r <= S_MED_A;
          end
        end
        S_MED_A: state_r <= S_MED_R;
        S_MED_R: begin
          state_r <= (CmpW'(ru_cnt) >= CmpW'(thr) && open_ok) ? S_SP_RD_A : S_BP_A;
        end
        // open: take spare at pick, close the gap, push onto used front
        S_SP_RD_A: begin
          i_r     <= pick_q;
          state_r <= S_SP_RD_R;
        end
        S_SP_RD_R: begin
          res_id_r <= s_rdata;
          k_r      <= i_r;
          state_r  <= S_SPSH_A;
        end
        S_SPSH_A: begin
          if (k_inc < spare_total_r) begin
            state_r <= S_SPSH_R;
          end else begin
            spare_total_r <= spare_total_r - TotW'(1);
            hold_r        <= {res_id_r, CountWidth'(1)};
            k_r           <= '0;
            state_r       <= S_USH_A;
          end
        end
        S_SPSH_R: begin
          k_r     <= k_inc;
          state_r <= S_SPSH_A;
        end
        S_USH_A: begin
          if (k_r <= used_total_r) begin
            state_r <= S_USH_R;
          end else begin
            used_total_r <= used_total_r + TotW'(1);
            res_oc_r     <= OUT_OPENED;
            state_r      <= S_DONE;
          end
        end
        S_USH_R: begin
          hold_r  <= u_rdata;
          k_r     <= k_inc;
          state_r <= S_USH_A;
        end
        // bump: lower-half pick, walk right past strictly lower counts
        S_BP_A: begin
          res_oc_r <= OUT_EXISTING;
          if (half == '0) begin
            res_id_r <= '0;
            state_r  <= S_DONE;
          end else begin
            i_r     <= pick_q;
            k_r     <= pick_q;
            state_r <= S_BP_R;
          end
        end
        S_BP_R: begin
          res_id_r <= ru_id;
          cnt_r    <= cnt_inc;
          state_r  <= S_BP_SCAN_A;
        end
        S_BP_SCAN_A: begin
          state_r <= (k_inc < used_total_r) ? S_BP_SCAN_R : S_FIN_A;
        end
        S_BP_SCAN_R: begin
          if (cnt_r > ru_cnt) begin
            hold_r  <= u_rdata;
            k_r     <= k_inc;
            state_r <= S_BP_SCAN_A;
          end else begin
            state_r <= S_FIN_A;
          end
        end
        // remove: linear search for the id
        S_RM_A: begin
          if (k_r < used_total_r) begin
            state_r <= S_RM_R;
          end else begin
            res_oc_r <= OUT_IGNORED;
            state_r  <= S_DONE;
          end
        end
        S_RM_R: begin
          if (ru_id == bid_r) begin
            i_r      <= k_r;
            res_id_r <= ru_id;
            if (ru_cnt <= CountWidth'(1)) begin
              state_r <= S_RF_A;
            end else begin
              cnt_r    <= ru_cnt - CountWidth'(1);
              res_oc_r <= OUT_DECR;
              state_r  <= S_RD_A;
            end
          end else begin
            k_r     <= k_inc;
            state_r <= S_RM_A;
          end
        end
        // free: close the gap in the used list, return id to spares
        S_RF_A: begin
          if (k_inc < used_total_r) begin
            state_r <= S_RF_R;
          end else begin
            used_total_r <= used_total_r - TotW'(1);
            state_r      <= S_RF_SP;
          end
        end
        S_RF_R: begin
          k_r     <= k_inc;
          state_r <= S_RF_A;
        end
        S_RF_SP: begin
          if (spare_total_r < TotW'(NumBuckets)) spare_total_r <= spare_total_r + TotW'(1);
          res_oc_r <= OUT_FREED;
          state_r  <= S_DONE;
        end
        // decrement: walk left past strictly higher counts
        S_RD_A: begin
          state_r <= (k_r != '0) ? S_RD_R : S_FIN_A;
        end
        S_RD_R: begin
          if (ru_cnt > cnt_r) begin
            hold_r  <= u_rdata;
            k_r     <= k_dec;
            state_r <= S_RD_A;
          end else begin
            state_r <= S_FIN_A;
          end
        end
        S_FIN_A: state_r <= S_FIN_B;
        S_FIN_B: state_r <= S_DONE;
        S_DONE: if (out_free) begin
          od_r.chosen_bucket <= (cmd_r == CMD_REMOVE) ? bid_r : res_id_r;
          od_r.outcome       <= res_oc_r;
          state_r            <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data));
  a_totals: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |->
      ({1'b0, used_total_r} + {1'b0, spare_total_r}) == (TotW+1)'(NumBuckets));
  a_used_max: assert property (@(posedge clk) disable iff (!rst_n)
    used_total_r <= TotW'(NumBuckets));
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall);
`endif

endmodule

// File: dv/tb_balanced_folder_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_balanced_folder_allocator_top
// Self-checking bench for the balanced bucket allocator: a queue-fed driver
// offers allocate/remove beats, a shadow copy of the sorted in-use list and
// the spare list predicts each result, and a monitor compares every result
// beat with the oldest prediction under several idle and stall phases.
// ----------------------------------------------------------------------------
module tb_balanced_folder_allocator_top;
  import bfa_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  always #1 clk = ~clk;

  balanced_folder_allocator_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Shadow of the allocator lists.
  logic [IdxW-1:0]       sh_used_id  [NumBuckets];
  logic [CountWidth-1:0] sh_used_cnt [NumBuckets];
  int unsigned           sh_used_n;
  logic [IdxW-1:0]       sh_spare_id [NumBuckets];
  int unsigned           sh_spare_n;

  in_beat_t  req_q[$];      // beats waiting for the driver
  out_beat_t want_q[$];     // predicted result beats, oldest first
  int        fail_cnt = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  logic      hold_on = 1'b0;  // receiver hold-off, timed by its own process

  function automatic int unsigned rnd_pick(logic [31:0] r, int unsigned n);
    logic [63:0] prod;
    prod = {32'd0, r} * 64'(n);
    return int'(prod[63:32]);
  endfunction

  // Predict one result beat and advance the shadow lists.
  function automatic out_beat_t alloc_predict(in_beat_t b);
    out_beat_t o;
    int unsigned half, i, k, pos;
    logic [IdxW-1:0] id, tid;
    logic [CountWidth-1:0] cnt, tc;
    bit open_new;
    o = '0;
    if (b.cmd == CMD_ALLOC) begin
      half = sh_used_n / 2;
      open_new = (half < MinOpenHalf) ||
                 ((64'(sh_used_cnt[half % NumBuckets]) >= 64'(3 * sh_used_n / 2)) &&
                  sh_spare_n != 0);
      if (sh_spare_n == 0 || sh_used_n >= NumBuckets) open_new = 1'b0;
      if (open_new) begin
        i = rnd_pick(b.random_word, sh_spare_n);
        id = sh_spare_id[i];
        for (k = i; k + 1 < sh_spare_n; k++) sh_spare_id[k] = sh_spare_id[k+1];
        sh_spare_n--;
        for (k = sh_used_n; k > 0; k--) begin
          sh_used_id[k]  = sh_used_id[k-1];
          sh_used_cnt[k] = sh_used_cnt[k-1];
        end
        sh_used_id[0] = id;
        sh_used_cnt[0] = 1;
        sh_used_n++;
        o.chosen_bucket = id;
        o.outcome = OUT_OPENED;
      end else if (half == 0) begin
        o.outcome = OUT_EXISTING;
      end else begin
        i = rnd_pick(b.random_word, half);
        cnt = sh_used_cnt[i];
        if (cnt != CountMax) cnt++;
        sh_used_cnt[i] = cnt;
        pos = i;
        while (pos + 1 < sh_used_n && cnt > sh_used_cnt[pos+1]) pos++;
        tid = sh_used_id[i];  tc = sh_used_cnt[i];
        sh_used_id[i] = sh_used_id[pos];  sh_used_cnt[i] = sh_used_cnt[pos];
        sh_used_id[pos] = tid;  sh_used_cnt[pos] = tc;
        o.chosen_bucket = sh_used_id[pos];
        o.outcome = OUT_EXISTING;
      end
    end else begin
      o.chosen_bucket = b.bucket_id;
      for (i = 0; i < sh_used_n; i++) if (sh_used_id[i] == b.bucket_id) break;
      if (i >= sh_used_n) begin
        o.outcome = OUT_IGNORED;
      end else if (sh_used_cnt[i] <= 1) begin
        if (sh_spare_n < NumBuckets) begin
          sh_spare_id[sh_spare_n] = b.bucket_id;
          sh_spare_n++;
        end
        for (k = i; k + 1 < sh_used_n; k++) begin
          sh_used_id[k]  = sh_used_id[k+1];
          sh_used_cnt[k] = sh_used_cnt[k+1];
        end
        sh_used_n--;
        o.outcome = OUT_FREED;
      end else begin
        cnt = sh_used_cnt[i] - 1;
        sh_used_cnt[i] = cnt;
        pos = i;
        while (pos > 0 && sh_used_cnt[pos-1] > cnt) pos--;
        tid = sh_used_id[i];  tc = sh_used_cnt[i];
        sh_used_id[i] = sh_used_id[pos];  sh_used_cnt[i] = sh_used_cnt[pos];
        sh_used_id[pos] = tid;  sh_used_cnt[pos] = tc;
        o.outcome = OUT_DECR;
      end
    end
    return o;
  endfunction

  // Driver: valid is held with a stable payload until accepted. Idle gaps
  // are only inserted between beats, never under a pending one.
  always @(posedge clk) begin
    out_beat_t pred;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pred = alloc_predict(in_data);
        want_q.insert(want_q.size(), pred);
        void'(req_q.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        // take next beat (queue head after any pop above)
        if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= req_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor plus receiver stall generation.
  always @(posedge clk) begin
    out_beat_t w;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (want_q.size() == 0) begin
          $error("unexpected result beat bucket=%0d outcome=%0d",
                 out_data.chosen_bucket, out_data.outcome);
          fail_cnt++;
        end else begin
          w = want_q.pop_front();
          if (out_data.chosen_bucket !== w.chosen_bucket) begin
            $error("chosen_bucket expected %0d actual %0d",
                   w.chosen_bucket, out_data.chosen_bucket);
            fail_cnt++;
          end
          if (out_data.outcome !== w.outcome) begin
            $error("outcome expected %0d actual %0d", w.outcome, out_data.outcome);
            fail_cnt++;
          end
        end
      end
      out_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic wait_drained();
    while (req_q.size() != 0 || in_valid || want_q.size() != 0) @(posedge clk);
  endtask

  task automatic add_req(cmd_t c, logic [7:0] id, logic [31:0] r);
    in_beat_t b;
    b.cmd = c;
    b.bucket_id = id;
    b.random_word = r;
    req_q.insert(req_q.size(), b);
  endtask

  // Random mix: mostly allocates, removes aimed at live buckets, some noise.
  task automatic load_random(int n);
    int unsigned k;
    logic [7:0] id;
    for (int j = 0; j < n; j++) begin
      k = $urandom_range(99);
      if (k < 55) begin
        add_req(CMD_ALLOC, 8'($urandom), $urandom);
      end else begin
        id = (k < 90 && sh_used_n != 0) ? sh_used_id[$urandom_range(sh_used_n - 1)]
                                        : 8'($urandom);
        add_req(CMD_REMOVE, id, $urandom);
      end
    end
  endtask

  initial begin
    sh_used_n  = 0;
    sh_spare_n = NumBuckets;
    for (int j = 0; j < NumBuckets; j++) sh_spare_id[j] = IdxW'(j);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-list removes, random_word extremes, open path,
    // remove of live / dead ids, decrement and free.
    add_req(CMD_REMOVE, 8'd0, 32'd0);
    add_req(CMD_REMOVE, 8'hFF, 32'hFFFF_FFFF);
    add_req(CMD_ALLOC, 8'hFF, 32'd0);
    add_req(CMD_ALLOC, 8'h00, 32'hFFFF_FFFF);
    for (int j = 0; j < 14; j++) add_req(CMD_ALLOC, 8'($urandom), $urandom);
    add_req(CMD_ALLOC, 8'h00, 32'd0);
    add_req(CMD_ALLOC, 8'hFF, 32'hFFFF_FFFF);
    add_req(CMD_REMOVE, 8'd0, 32'hFFFF_FFFF);
    add_req(CMD_REMOVE, 8'd255, 32'd0);
    add_req(CMD_REMOVE, 8'd128, 32'h8000_0000);
    wait_drained();
    // removes chosen from the live shadow list: the last entry, then the front one
    if (sh_used_n > 0) begin
      add_req(CMD_REMOVE, sh_used_id[sh_used_n-1], $urandom);
      add_req(CMD_REMOVE, sh_used_id[0], $urandom);
    end
    wait_drained();

    // Phase: no idling.
    load_random(200);
    wait_drained();
    // Long receiver hold-off while the sender keeps offering beats.
    fork
      begin
        hold_on <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
    load_random(40);
    wait_drained();
    // Sender idle 50%.
    send_idle_pct = 50;
    load_random(180);
    wait_drained();
    // Receiver stalling 50%.
    send_idle_pct = 0;
    recv_stall_pct = 50;
    load_random(180);
    wait_drained();
    // Both 21%.
    send_idle_pct = 21;
    recv_stall_pct = 21;
    load_random(180);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (6 * NumBuckets + 20) @(posedge clk);

    if (fail_cnt == 0 && want_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // ~805 beats plus stalls, the long hold-off and the clearing pass stay
  // far below this.
  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
